// File: hdl/isort_pkg.sv
package isort_pkg;

    localparam int CAPACITY = 16;
    localparam int DATA_W   = 32;

    typedef struct packed {
        logic signed [DATA_W-1:0] sample_value;
        logic                     batch_end;
    } t_in_beat;

    typedef struct packed {
        logic signed [DATA_W-1:0] sorted_value;
        logic                     final_flag;
        logic                     overflow;
    } t_out_beat;

    typedef struct packed {
        logic insert;
        logic shift;
    } t_cell_ctrl;

endpackage

// File: hdl/isort_cell.sv
module isort_cell (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  isort_pkg::t_cell_ctrl               i_ctrl,
    input  logic signed [isort_pkg::DATA_W-1:0] i_value,
    input  logic signed [isort_pkg::DATA_W-1:0] i_left_value,
    input  logic                                i_left_valid,
    input  logic                                i_left_gt,
    input  logic signed [isort_pkg::DATA_W-1:0] i_right_value,
    input  logic                                i_right_valid,
    output logic signed [isort_pkg::DATA_W-1:0] o_value,
    output logic                                o_valid,
    output logic                                o_gt
);

    logic signed [isort_pkg::DATA_W-1:0] r_value;
    logic signed [isort_pkg::DATA_W-1:0] n_value;
    logic                                r_valid;
    logic                                n_valid;
    logic                                w_gt;

    // The stored value is strictly greater, so an equal newcomer lands behind it.
    assign w_gt = r_valid && (r_value > i_value);

    always_comb begin
        n_value = r_value;
        n_valid = r_valid;
        if (i_ctrl.shift) begin
            n_value = i_right_value;
            n_valid = i_right_valid;
        end else if (i_ctrl.insert) begin
            if (i_left_gt) begin
                n_value = i_left_value;
                n_valid = 1'b1;
            end else if (w_gt || (!r_valid && i_left_valid)) begin
                n_value = i_value;
                n_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;
    assign o_valid = r_valid;
    assign o_gt    = w_gt;

endmodule

// File: hdl/insertion_sorter.sv
// Channel  Direction  Handshake               Payload
// input    in         i_in_valid / o_in_stall   isort_pkg::t_in_beat
// output   out        o_out_valid / i_out_stall isort_pkg::t_out_beat
//
// One input beat per cycle is inserted by the row of compare-and-shift cells while
// the row is not draining; a beat that finds the row full is dropped. A beat with
// batch_end closes the batch; the row then shifts its contents out through cell zero,
// one result beat per cycle unless the output stalls, while the input is stalled.
// Reset empties every cell and clears the drop flag; the store values are not reset.
// An output stall freezes the row, so the presented beat holds.
module insertion_sorter (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  isort_pkg::t_in_beat   i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output isort_pkg::t_out_beat  o_out_data
);

    localparam int N = isort_pkg::CAPACITY;

    logic signed [isort_pkg::DATA_W-1:0] w_value [N];
    logic                                w_valid [N];
    logic                                w_gt    [N];

    logic                  r_drain;
    logic                  n_drain;
    logic                  r_dropped;
    logic                  n_dropped;
    logic                  w_in_acc;
    logic                  w_out_acc;
    logic                  w_full;
    logic                  w_last;
    isort_pkg::t_cell_ctrl w_ctrl;

    assign w_in_acc  = i_in_valid && !r_drain;
    assign w_out_acc = r_drain && !i_out_stall;
    assign w_full    = w_valid[N-1];
    assign w_last    = !w_valid[1];

    assign w_ctrl.insert = w_in_acc && !w_full;
    assign w_ctrl.shift  = w_out_acc;

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_cell
            logic signed [isort_pkg::DATA_W-1:0] w_lv;
            logic                                w_lval;
            logic                                w_lgt;
            logic signed [isort_pkg::DATA_W-1:0] w_rv;
            logic                                w_rval;

            if (g == 0) begin : g_head
                assign w_lv   = '0;
                assign w_lval = 1'b1;
                assign w_lgt  = 1'b0;
            end else begin : g_body
                assign w_lv   = w_value[g-1];
                assign w_lval = w_valid[g-1];
                assign w_lgt  = w_gt[g-1];
            end

            if (g == N-1) begin : g_tail
                assign w_rv   = '0;
                assign w_rval = 1'b0;
            end else begin : g_mid
                assign w_rv   = w_value[g+1];
                assign w_rval = w_valid[g+1];
            end

            isort_cell u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_ctrl        (w_ctrl),
                .i_value       (i_in_data.sample_value),
                .i_left_value  (w_lv),
                .i_left_valid  (w_lval),
                .i_left_gt     (w_lgt),
                .i_right_value (w_rv),
                .i_right_valid (w_rval),
                .o_value       (w_value[g]),
                .o_valid       (w_valid[g]),
                .o_gt          (w_gt[g])
            );
        end
    endgenerate

    always_comb begin
        n_drain   = r_drain;
        n_dropped = r_dropped;
        if (w_in_acc) begin
            if (w_full) begin
                n_dropped = 1'b1;
            end
            if (i_in_data.batch_end) begin
                n_drain = 1'b1;
            end
        end
        if (w_out_acc && w_last) begin
            n_drain   = 1'b0;
            n_dropped = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drain   <= 1'b0;
            r_dropped <= 1'b0;
        end else begin
            r_drain   <= n_drain;
            r_dropped <= n_dropped;
        end
    end

    assign o_in_stall              = r_drain;
    assign o_out_valid             = r_drain;
    assign o_out_data.sorted_value = w_value[0];
    assign o_out_data.final_flag   = w_last;
    assign o_out_data.overflow     = r_dropped;

endmodule

// File: hdl/isort_checker.sv
module isort_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 i_in_stall,
    input isort_pkg::t_in_beat  i_in_data,
    input logic                 i_out_valid,
    input logic                 i_out_stall,
    input isort_pkg::t_out_beat i_out_data
);

    // A closing input beat starts the drain on the next cycle.
    a_close_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !i_in_stall && i_in_data.batch_end) |=> i_out_valid)
        else $error("closing beat did not start the drain");

    // The input stays stalled while results are being delivered.
    a_stall_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_in_stall)
        else $error("input accepted during drain");

    // The drain stops right after the final result beat.
    a_final_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_stall && i_out_data.final_flag) |=> !i_out_valid)
        else $error("results continued after final beat");

    // Overflow is the same on every result of one batch.
    a_overflow_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_stall && !i_out_data.final_flag) |=>
        (i_out_valid && i_out_data.overflow == $past(i_out_data.overflow)))
        else $error("overflow changed within a batch");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_stall) |=> (i_out_valid && $stable(i_out_data)))
        else $error("stalled result beat changed");

endmodule

bind insertion_sorter isort_checker u_isort_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_data  (o_out_data)
);

// File: tb/sv/tb_insertion_sorter.sv
module tb_insertion_sorter;

    typedef enum int {
        RX_FREE,
        RX_RANDOM,
        RX_PERIODIC
    } t_rx_mode;

    localparam logic signed [isort_pkg::DATA_W-1:0] MIN_VALUE =
        {1'b1, {(isort_pkg::DATA_W-1){1'b0}}};
    localparam logic signed [isort_pkg::DATA_W-1:0] MAX_VALUE =
        {1'b0, {(isort_pkg::DATA_W-1){1'b1}}};
    localparam int TAIL_CYCLES  = 2 * isort_pkg::CAPACITY + 8;
    localparam int LIMIT_CYCLES = 200000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    isort_pkg::t_in_beat  in_beat = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    isort_pkg::t_out_beat out_beat;

    logic signed [isort_pkg::DATA_W-1:0] batch_store[$];
    logic                                batch_dropped = 1'b0;
    isort_pkg::t_out_beat                pending_results[$];
    int                                  error_count = 0;

    bit       sender_gaps = 1'b0;
    int       burst_left = 0;
    t_rx_mode rx_mode = RX_FREE;
    int       hold_left = 0;
    int       rx_tick = 0;

    insertion_sorter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_beat)
    );

    always #5 i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    // Inserts after every stored value that is less than or equal, so equal values keep order.
    function automatic void predict_sorted_batch(input isort_pkg::t_in_beat beat);
        logic signed [isort_pkg::DATA_W-1:0] value;
        int pos;
        isort_pkg::t_out_beat res;
        value = beat.sample_value;
        if (batch_store.size() >= isort_pkg::CAPACITY) begin
            batch_dropped = 1'b1;
        end else begin
            pos = 0;
            while (pos < batch_store.size() && batch_store[pos] <= value) pos++;
            batch_store.insert(pos, value);
        end
        if (beat.batch_end) begin
            foreach (batch_store[k]) begin
                res.sorted_value = batch_store[k];
                res.final_flag   = (k == batch_store.size() - 1);
                res.overflow     = batch_dropped;
                pending_results.push_back(res);
            end
            batch_store.delete();
            batch_dropped = 1'b0;
        end
    endfunction

    always @(posedge i_clk) begin
        isort_pkg::t_out_beat want;
        if (i_rst_n) begin
            if (in_valid && in_stall === 1'b0) predict_sorted_batch(in_beat);
            if (out_valid === 1'b1 && !out_stall) begin
                if (pending_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result beat %p", out_beat));
                end else begin
                    want = pending_results.pop_front();
                    if (out_beat.sorted_value !== want.sorted_value)
                        report_mismatch($sformatf("sorted_value %0d, expected %0d",
                                                  out_beat.sorted_value, want.sorted_value));
                    if (out_beat.final_flag !== want.final_flag)
                        report_mismatch($sformatf("final_flag %b, expected %b",
                                                  out_beat.final_flag, want.final_flag));
                    if (out_beat.overflow !== want.overflow)
                        report_mismatch($sformatf("overflow %b, expected %b",
                                                  out_beat.overflow, want.overflow));
                end
            end
        end
    end

    // The receiver honors a long hold first, then stalls on its current pattern.
    always @(negedge i_clk) begin
        rx_tick = rx_tick + 1;
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end else begin
            case (rx_mode)
                RX_RANDOM: begin
                    out_stall <= ($urandom_range(0, 2) == 0);
                end
                RX_PERIODIC: begin
                    out_stall <= ((rx_tick % 11) < 4);
                end
                default: begin
                    out_stall <= 1'b0;
                end
            endcase
        end
    end

    task automatic send_sample(input logic signed [isort_pkg::DATA_W-1:0] value,
                               input logic last);
        isort_pkg::t_in_beat beat;
        int gap;
        if (sender_gaps && burst_left == 0) begin
            gap = $urandom_range(1, 6);
            @(negedge i_clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
            burst_left = $urandom_range(1, 8);
        end
        beat.sample_value = value;
        beat.batch_end    = last;
        @(negedge i_clk);
        in_valid <= 1'b1;
        in_beat  <= beat;
        @(posedge i_clk);
        while (in_stall !== 1'b0) @(posedge i_clk);
        if (burst_left > 0) burst_left--;
    endtask

    function automatic logic signed [isort_pkg::DATA_W-1:0] pick_sample_value();
        logic signed [isort_pkg::DATA_W-1:0] value;
        case ($urandom_range(0, 9))
            6, 7: value = $signed($urandom_range(0, 8)) - 4;
            8: begin
                case ($urandom_range(0, 3))
                    0: value = MIN_VALUE;
                    1: value = MAX_VALUE;
                    2: value = '0;
                    default: value = -1;
                endcase
            end
            9: value = $urandom_range(0, 1) ? MIN_VALUE + $urandom_range(0, 3)
                                            : MAX_VALUE - $urandom_range(0, 3);
            default: value = $urandom;
        endcase
        return value;
    endfunction

    task automatic send_batch(input int count);
        for (int i = 0; i < count; i++) send_sample(pick_sample_value(), i == count - 1);
    endtask

    task automatic test_extremes();
        logic signed [isort_pkg::DATA_W-1:0] mixed[6];
        mixed = '{0, -1, 1, MAX_VALUE, MIN_VALUE, -1};
        send_sample(MIN_VALUE, 1'b1);
        send_sample(MAX_VALUE, 1'b1);
        foreach (mixed[i]) send_sample(mixed[i], i == 5);
    endtask

    // The closing value of this batch arrives with the store full and is dropped.
    task automatic test_store_full();
        for (int i = 0; i <= isort_pkg::CAPACITY; i++)
            send_sample((i % 2) ? MAX_VALUE - i : MIN_VALUE + i, i == isort_pkg::CAPACITY);
    endtask

    task automatic test_random_batches(input int item_goal);
        int sent;
        int count;
        sent = 0;
        while (sent < item_goal) begin
            sender_gaps = ($urandom_range(0, 3) != 0);
            rx_mode     = t_rx_mode'($urandom_range(0, 2));
            case ($urandom_range(0, 9))
                7, 8: count = $urandom_range(9, isort_pkg::CAPACITY);
                9: count = $urandom_range(isort_pkg::CAPACITY + 1, isort_pkg::CAPACITY + 8);
                default: count = $urandom_range(1, 8);
            endcase
            send_batch(count);
            sent += count;
        end
    endtask

    // The receiver holds off while batches keep coming, so the row fills and its held drain stalls the input.
    task automatic test_receiver_hold();
        sender_gaps = 1'b0;
        rx_mode     = RX_FREE;
        @(posedge i_clk);
        hold_left = 300;
        send_batch(isort_pkg::CAPACITY);
        send_batch(isort_pkg::CAPACITY + 2);
        send_batch(6);
        rx_mode = RX_RANDOM;
    endtask

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        rx_mode = RX_RANDOM;
        test_extremes();
        test_store_full();
        test_random_batches(280);
        test_receiver_hold();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d result beats never arrived", pending_results.size()));
        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        repeat (LIMIT_CYCLES) @(posedge i_clk);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: insertion_sorter.f
hdl/isort_pkg.sv
hdl/isort_cell.sv
hdl/insertion_sorter.sv
hdl/isort_checker.sv
tb/sv/tb_insertion_sorter.sv
